[rtl/i2ccrw_pkg.sv]
`default_nettype none
package i2ccrw_pkg;

    localparam int DEV_ADDR_W         = 7;
    localparam int HALF_W             = 16;
    localparam int REG_W              = 7;
    localparam int VAL_W              = 9;
    localparam int CFG_IDX_W          = 1;
    localparam int CFG_DATA_W         = 16;
    localparam int REGISTER_COUNT_DEF = 58;

    localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RST = 7'd26;
    localparam logic [HALF_W-1:0]     HALF_RST     = 16'd180;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD_TICKS = 1'd1;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_START_HOLD  = 4'd1,
        PH_START_LOW   = 4'd2,
        PH_BIT_SETUP   = 4'd3,
        PH_BIT_HIGH    = 4'd4,
        PH_ACK_RELEASE = 4'd5,
        PH_ACK_HIGH    = 4'd6,
        PH_ACK_LOW     = 4'd7,
        PH_STOP_LOW    = 4'd8,
        PH_STOP_SCL    = 4'd9,
        PH_STOP_SDA    = 4'd10
    } t_phase;

    typedef struct packed {
        logic             start_request;
        logic [REG_W-1:0] write_reg;
        logic [VAL_W-1:0] write_value;
        logic             sda_in;
        logic [REG_W-1:0] read_index;
    } t_item;

    typedef struct packed {
        logic scl;
        logic sda;
        logic busy;
        logic done;
        logic success;
        logic rejected;
    } t_seq_res;

    typedef struct packed {
        logic             we;
        logic [REG_W-1:0] addr;
        logic [VAL_W-1:0] data;
    } t_shadow_wr;

endpackage
`default_nettype wire

[rtl/i2ccrw_req_if.sv]
`default_nettype none
interface i2ccrw_req_if;
    import i2ccrw_pkg::*;

    logic             valid;
    logic             ready;
    logic             start_request;
    logic [REG_W-1:0] write_reg;
    logic [VAL_W-1:0] write_value;
    logic             sda_in;
    logic [REG_W-1:0] read_index;

    modport source (
        output valid, start_request, write_reg, write_value, sda_in, read_index,
        input  ready
    );
    modport sink (
        input  valid, start_request, write_reg, write_value, sda_in, read_index,
        output ready
    );
endinterface
`default_nettype wire

[rtl/i2ccrw_res_if.sv]
`default_nettype none
interface i2ccrw_res_if;
    import i2ccrw_pkg::*;

    logic             valid;
    logic             ready;
    logic             scl_out;
    logic             sda_out;
    logic             busy_res;
    logic             done_res;
    logic             success;
    logic             rejected;
    logic [VAL_W-1:0] read_data;

    modport source (
        output valid, scl_out, sda_out, busy_res, done_res, success, rejected,
               read_data,
        input  ready
    );
    modport sink (
        input  valid, scl_out, sda_out, busy_res, done_res, success, rejected,
               read_data,
        output ready
    );
endinterface
`default_nettype wire

[rtl/i2c_codec_register_writer.sv]
`default_nettype none
// I2C write master for a codec control port. Each request transaction is one
// timing tick: it may carry a write request and the sampled SDA level, and it
// yields exactly one result transaction with the SCL/SDA drive for that tick,
// busy/done/success/rejected flags and one shadow store entry. A tick is taken
// every clock cycle when the result side keeps up; each tick passes the input
// register, then the sequencer pass into the result register. A write
// sends start, address+W, register<<1 with value bit 8, low value byte, each
// followed by an acknowledge slot, and a stop; every line level lasts
// half_period_ticks ticks (0 acts as 1). Register numbers at or above
// REGISTER_COUNT are rejected on the same tick. The shadow store needs no
// clearing pass: per-entry valid bits make unwritten entries read as zero.
module i2c_codec_register_writer #(
    parameter int REGISTER_COUNT = i2ccrw_pkg::REGISTER_COUNT_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    i2ccrw_req_if.sink                           i_req_chan,
    i2ccrw_res_if.source                         o_res_chan,
    input  wire                                  i_cfg_we,
    input  wire [i2ccrw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire [i2ccrw_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import i2ccrw_pkg::*;

    // configuration registers
    logic [DEV_ADDR_W-1:0] r_device_address;
    logic [HALF_W-1:0]     r_half_period_ticks;

    // input stage
    logic  r_s1_valid;
    t_item r_s1;

    // result stage
    logic     r_out_valid;
    t_seq_res r_res;

    logic             w_adv;
    t_seq_res         w_seq_res;
    t_shadow_wr       w_wr;
    logic [VAL_W-1:0] w_rd_data;

    // the input stage moves into the result register when that is free or
    // being drained; a new tick is taken only while the input stage is empty
    // or moving on
    assign w_adv            = r_s1_valid && (!r_out_valid || o_res_chan.ready);
    assign i_req_chan.ready = !r_s1_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address    <= DEV_ADDR_RST;
            r_half_period_ticks <= HALF_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEVICE_ADDRESS:    r_device_address    <= i_cfg_data[DEV_ADDR_W-1:0];
                CFG_HALF_PERIOD_TICKS: r_half_period_ticks <= i_cfg_data[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req_chan.ready) begin
            r_s1_valid <= i_req_chan.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req_chan.valid && i_req_chan.ready) begin
            r_s1.start_request <= i_req_chan.start_request;
            r_s1.write_reg     <= i_req_chan.write_reg;
            r_s1.write_value   <= i_req_chan.write_value;
            r_s1.sda_in        <= i_req_chan.sda_in;
            r_s1.read_index    <= i_req_chan.read_index;
        end
    end

    // bus sequencer: one tick per advance
    i2ccrw_seq #(
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_seq (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_en                (w_adv),
        .i_item              (r_s1),
        .i_device_address    (r_device_address),
        .i_half_period_ticks (r_half_period_ticks),
        .o_res               (w_seq_res),
        .o_wr                (w_wr)
    );

    // shadow store; its registered read forms part of the result register
    i2ccrw_shadow #(
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_shadow (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_adv),
        .i_wr      (w_wr),
        .i_rd_idx  (r_s1.read_index),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res_chan.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= w_seq_res;
        end
    end

    assign o_res_chan.valid     = r_out_valid;
    assign o_res_chan.scl_out   = r_res.scl;
    assign o_res_chan.sda_out   = r_res.sda;
    assign o_res_chan.busy_res  = r_res.busy;
    assign o_res_chan.done_res  = r_res.done;
    assign o_res_chan.success   = r_res.success;
    assign o_res_chan.rejected  = r_res.rejected;
    assign o_res_chan.read_data = w_rd_data;

`ifndef ASSERT_OFF
    // a finishing tick always leaves the sequencer idle
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.done && r_res.busy))
        else $error("done reported while still busy");

    // a rejection is a done without success
    a_reject_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.rejected) |-> (r_res.done && !r_res.success))
        else $error("malformed rejection result");

    // a held input stage is never dropped
    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_adv) |=> r_s1_valid)
        else $error("input stage lost a tick");

    // a shadow write happens only on a successful done
    a_wr_on_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_wr.we) |=> (r_res.done && r_res.success))
        else $error("shadow write without a successful transaction");
`endif

endmodule
`default_nettype wire

[rtl/i2ccrw_seq.sv]
`default_nettype none
module i2ccrw_seq #(
    parameter int REGISTER_COUNT = i2ccrw_pkg::REGISTER_COUNT_DEF
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_en,
    input  i2ccrw_pkg::t_item                       i_item,
    input  wire [i2ccrw_pkg::DEV_ADDR_W-1:0]        i_device_address,
    input  wire [i2ccrw_pkg::HALF_W-1:0]            i_half_period_ticks,
    output i2ccrw_pkg::t_seq_res                    o_res,
    output i2ccrw_pkg::t_shadow_wr                  o_wr
);
    import i2ccrw_pkg::*;

    localparam logic [REG_W:0] CountW = (REG_W+1)'(REGISTER_COUNT);

    t_phase           r_phase,     n_phase;
    logic [3:0]       r_bit_cnt,   n_bit_cnt;
    logic [1:0]       r_byte_cnt,  n_byte_cnt;
    logic [7:0]       r_shift,     n_shift;
    logic [HALF_W-1:0] r_wait,     n_wait;
    logic             r_all_acked, n_all_acked;
    logic [REG_W-1:0] r_pend_reg,  n_pend_reg;
    logic [VAL_W-1:0] r_pend_val,  n_pend_val;

    logic [HALF_W-1:0] w_reload;
    logic              w_in_range;
    logic              w_reject;
    logic              w_finish;

    // zero half period behaves as one
    assign w_reload   = (i_half_period_ticks == '0) ? '0 : i_half_period_ticks - 1'b1;
    assign w_in_range = {1'b0, i_item.write_reg} < CountW;

    always_comb begin
        n_phase     = r_phase;
        n_bit_cnt   = r_bit_cnt;
        n_byte_cnt  = r_byte_cnt;
        n_shift     = r_shift;
        n_wait      = r_wait;
        n_all_acked = r_all_acked;
        n_pend_reg  = r_pend_reg;
        n_pend_val  = r_pend_val;
        if (r_phase == PH_IDLE) begin
            if (i_item.start_request && w_in_range) begin
                n_pend_reg  = i_item.write_reg;
                n_pend_val  = i_item.write_value;
                n_all_acked = 1'b1;
                n_byte_cnt  = 2'd0;
                n_bit_cnt   = 4'd0;
                n_shift     = {i_device_address, 1'b0};
                n_phase     = PH_START_HOLD;
                n_wait      = w_reload;
            end
        end else if (r_wait != '0) begin
            n_wait = r_wait - 1'b1;
        end else begin
            n_wait = w_reload;
            case (r_phase)
                PH_START_HOLD: n_phase = PH_START_LOW;
                PH_START_LOW: begin
                    n_bit_cnt = 4'd0;
                    n_phase   = PH_BIT_SETUP;
                end
                PH_BIT_SETUP: n_phase = PH_BIT_HIGH;
                PH_BIT_HIGH: begin
                    if (r_bit_cnt >= 4'd7) begin
                        n_phase = PH_ACK_RELEASE;
                    end else begin
                        n_bit_cnt = r_bit_cnt + 4'd1;
                        n_shift   = {r_shift[6:0], 1'b0};
                        n_phase   = PH_BIT_SETUP;
                    end
                end
                PH_ACK_RELEASE: n_phase = PH_ACK_HIGH;
                PH_ACK_HIGH: begin
                    if (i_item.sda_in) begin
                        n_all_acked = 1'b0;
                    end
                    n_phase = PH_ACK_LOW;
                end
                PH_ACK_LOW: begin
                    if (r_byte_cnt >= 2'd2) begin
                        n_phase = PH_STOP_LOW;
                    end else begin
                        n_byte_cnt = r_byte_cnt + 2'd1;
                        n_bit_cnt  = 4'd0;
                        n_shift    = (r_byte_cnt == 2'd0) ? {r_pend_reg, r_pend_val[8]}
                                                          : r_pend_val[7:0];
                        n_phase    = PH_BIT_SETUP;
                    end
                end
                PH_STOP_LOW: n_phase = PH_STOP_SCL;
                PH_STOP_SCL: n_phase = PH_STOP_SDA;
                default: begin
                    // end of stop, or an unreachable code: back to idle
                    n_phase = PH_IDLE;
                    n_wait  = '0;
                end
            endcase
        end
    end

    assign w_reject = (r_phase == PH_IDLE) && i_item.start_request && !w_in_range;
    assign w_finish = (r_phase == PH_STOP_SDA) && (r_wait == '0);

    always_comb begin
        o_res.busy     = (n_phase != PH_IDLE);
        o_res.done     = w_reject || w_finish;
        o_res.success  = w_finish && r_all_acked;
        o_res.rejected = w_reject;
        o_wr.we        = w_finish && r_all_acked;
        o_wr.addr      = r_pend_reg;
        o_wr.data      = r_pend_val;
        case (n_phase)
            PH_START_LOW:   begin o_res.scl = 1'b1; o_res.sda = 1'b0;       end
            PH_BIT_SETUP:   begin o_res.scl = 1'b0; o_res.sda = n_shift[7]; end
            PH_BIT_HIGH:    begin o_res.scl = 1'b1; o_res.sda = n_shift[7]; end
            PH_ACK_RELEASE: begin o_res.scl = 1'b0; o_res.sda = 1'b1;       end
            PH_ACK_HIGH:    begin o_res.scl = 1'b1; o_res.sda = 1'b1;       end
            PH_ACK_LOW:     begin o_res.scl = 1'b0; o_res.sda = 1'b1;       end
            PH_STOP_LOW:    begin o_res.scl = 1'b0; o_res.sda = 1'b0;       end
            PH_STOP_SCL:    begin o_res.scl = 1'b1; o_res.sda = 1'b0;       end
            default:        begin o_res.scl = 1'b1; o_res.sda = 1'b1;       end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_cnt   <= '0;
            r_byte_cnt  <= '0;
            r_shift     <= '0;
            r_wait      <= '0;
            r_all_acked <= 1'b1;
            r_pend_reg  <= '0;
            r_pend_val  <= '0;
        end else if (i_en) begin
            r_phase     <= n_phase;
            r_bit_cnt   <= n_bit_cnt;
            r_byte_cnt  <= n_byte_cnt;
            r_shift     <= n_shift;
            r_wait      <= n_wait;
            r_all_acked <= n_all_acked;
            r_pend_reg  <= n_pend_reg;
            r_pend_val  <= n_pend_val;
        end
    end

endmodule
`default_nettype wire

[rtl/i2ccrw_shadow.sv]
`default_nettype none
module i2ccrw_shadow #(
    parameter int REGISTER_COUNT = i2ccrw_pkg::REGISTER_COUNT_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_en,
    input  i2ccrw_pkg::t_shadow_wr            i_wr,
    input  wire [i2ccrw_pkg::REG_W-1:0]       i_rd_idx,
    output logic [i2ccrw_pkg::VAL_W-1:0]      o_rd_data
);
    import i2ccrw_pkg::*;

    localparam int             AW     = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
    localparam logic [REG_W:0] CountW = (REG_W+1)'(REGISTER_COUNT);

    logic [VAL_W-1:0]          r_mem [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] r_valid;
    logic [VAL_W-1:0]          r_mem_q;
    logic [VAL_W-1:0]          r_fwd_val;
    logic                      r_use_fwd;
    logic                      r_zero;

    logic          w_rd_in_range;
    logic          w_fwd;
    logic [AW-1:0] w_rd_a;
    logic [AW-1:0] w_wr_a;

    // 7-bit index, so an address above 127 cannot occur; the casts cut or zero-pad it to AW bits
    assign w_rd_a        = AW'(i_rd_idx);
    assign w_wr_a        = AW'(i_wr.addr);
    assign w_rd_in_range = {1'b0, i_rd_idx} < CountW;
    assign w_fwd         = i_wr.we && (i_wr.addr == i_rd_idx);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_wr.we) begin
                r_mem[w_wr_a] <= i_wr.data;
            end
            if (w_rd_in_range) begin
                r_mem_q <= r_mem[w_rd_a];
            end
            r_fwd_val <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_use_fwd <= 1'b0;
            r_zero    <= 1'b1;
        end else if (i_en) begin
            if (i_wr.we) begin
                r_valid[w_wr_a] <= 1'b1;
            end
            r_use_fwd <= w_fwd;
            r_zero    <= !w_rd_in_range || (!r_valid[w_rd_a] && !w_fwd);
        end
    end

    assign o_rd_data = r_zero ? '0 : (r_use_fwd ? r_fwd_val : r_mem_q);

endmodule
`default_nettype wire
